// File: src/bf3s_pkg.sv
package bf3s_pkg;

  // Line store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Register field widths
  localparam int MODE_W   = 1;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Reset values of the registers
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(512);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(512);

  // Smallest frame edge
  localparam int MIN_EDGE = 3;

  // Divide by 9: floor(sum * RECIP_9 / 2^RECIP_SHIFT) is exact for sums up to 9*255
  localparam int SUM_W       = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  // Filter modes
  localparam logic MODE_AVERAGE = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  typedef logic [7:0] pix_t;

  // Window: index row*3 + col, row 0 oldest, col 2 newest
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    win_t win;
    logic last;
  } q_entry_t;

endpackage

// File: src/bf3s_queue.sv
module bf3s_queue
  import bf3s_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     full,
  output logic     empty
);

  q_entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/bf3s_front.sv
module bf3s_front
  import bf3s_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pix_t                in_pixel,
  input  logic [COL_W-1:0]    last_col,
  input  logic [ROW_W-1:0]    last_row,
  input  logic                q_full,
  output logic                q_push,
  output q_entry_t            q_data
);

  // Line stores: a holds row r-2, b holds row r-1
  pix_t mem_a [MAX_WIDTH];
  pix_t mem_b [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_fire, row_end, frame_end;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_prod_r;
  logic             s1_last_r;
  pix_t             s1_px_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             top_r, mid_r;
  logic             s1_go;

  win_t             win_r, win_nxt;

  assign row_end   = (col_r >= last_col);
  assign frame_end = (row_r >= last_row);

  // Stage 1 retires when it needs no queue slot or one is free
  assign s1_go    = s1_valid_r && (!s1_prod_r || !q_full);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  // Advance raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Shift the window by one column
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_r;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  assign q_push      = s1_go && s1_prod_r;
  assign q_data.win  = win_nxt;
  assign q_data.last = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        win_r <= win_nxt;
      end
    end
  end

  // Capture the beat and classify it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_pixel;
      s1_col_r  <= col_r;
      s1_prod_r <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_last_r <= row_end && frame_end;
    end
  end

  // Read the column above; hold the read data while stage 1 waits
  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_r <= mem_a[col_r];
      mid_r <= mem_b[col_r];
    end
  end

  // Move the column down by one row
  always_ff @(posedge clk) begin
    if (s1_go) begin
      mem_a[s1_col_r] <= mid_r;
      mem_b[s1_col_r] <= s1_px_r;
    end
  end

endmodule

// File: src/bf3s_back.sv
module bf3s_back
  import bf3s_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     filter_mode,
  input  logic     q_empty,
  input  q_entry_t q_data,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_t     out_pixel,
  output logic     out_last
);

  logic              back_en;

  logic              a_valid_r;
  logic [SUM_W-1:0]  a_sum_r, a_sum_nxt;
  pix_t              a_center_r;
  logic              a_last_r;

  logic              b_valid_r;
  logic [PROD_W-1:0] b_prod_r;
  pix_t              b_center_r;
  logic              b_last_r;

  logic              o_valid_r;
  pix_t              o_pixel_r, o_pixel_nxt;
  logic              o_last_r;

  pix_t              mean, diff;
  logic [8:0]        boosted;

  // Advance the whole back pipe unless the result register is held
  assign back_en   = !o_valid_r || out_ready;
  assign q_pop     = back_en && !q_empty;
  assign out_valid = o_valid_r;
  assign out_pixel = o_pixel_r;
  assign out_last  = o_last_r;

  // Sum the nine window pixels
  always_comb begin
    a_sum_nxt = '0;
    for (int k = 0; k < 9; k++) begin
      a_sum_nxt = a_sum_nxt + SUM_W'(q_data.win[k]);
    end
  end

  // Finish divide by 9 and apply the mode
  always_comb begin
    mean    = b_prod_r[RECIP_SHIFT +: 8];
    diff    = (mean > b_center_r) ? mean - b_center_r : b_center_r - mean;
    boosted = {1'b0, b_center_r} + {1'b0, diff};
    unique case (filter_mode)
      MODE_SHARPEN: o_pixel_nxt = boosted[8] ? 8'hFF : boosted[7:0];
      MODE_AVERAGE: o_pixel_nxt = mean;
      default:      o_pixel_nxt = mean;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (back_en) begin
      a_valid_r <= !q_empty;
      b_valid_r <= a_valid_r;
      o_valid_r <= b_valid_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (back_en) begin
      a_sum_r    <= a_sum_nxt;
      a_center_r <= q_data.win[4];
      a_last_r   <= q_data.last;
      b_prod_r   <= PROD_W'(a_sum_r) * PROD_W'(RECIP_9);
      b_center_r <= a_center_r;
      b_last_r   <= a_last_r;
      o_pixel_r  <= o_pixel_nxt;
      o_last_r   <= b_last_r;
    end
  end

endmodule

// File: src/box_filter_3x3_sharpen.sv
// 3x3 mean / sharpen filter for a raster stream of 8-bit grey pixels.
// Input channel: in_valid/in_ready with in_pixel_in, one pixel per beat in
// raster order. Output channel: out_valid/out_ready with out_pixel_out and
// out_frame_last; one beat per interior pixel, none for border pixels, and
// out_frame_last marks the final interior pixel of a frame.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
// mode (0), image width (1) or image height (2); write only while idle.
// Throughput is one pixel per clock unless the receiver stalls. The
// result for interior pixel (r-1, c-1) is presented after pixel (r, c)
// is accepted, by way of the line store read, the window update that
// queues the beat, the adder tree, the multiply by the reciprocal of 9
// and the output register.
// Reset clears the raster counters, the window, the queue and the pipe and
// loads mode average, 512x512. The line stores are not cleared: the first
// two rows of a frame fill them before any result uses them.
// When the receiver stalls the output register holds, the back pipe stops,
// and the front keeps taking pixels until the four-entry queue fills.
module box_filter_3x3_sharpen
  import bf3s_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel_out,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                mode_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    last_col;
  logic [ROW_W-1:0]    last_row;

  logic                q_full, q_empty, q_push, q_pop;
  q_entry_t            q_in, q_out;

  assign cfg_ready = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_AVERAGE;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp the frame size and form the last column and row
  always_comb begin
    priority if (width_r < WIDTH_W'(MIN_EDGE)) begin
      last_col = COL_W'(MIN_EDGE - 1);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(width_r - 1'b1);
    end
    priority if (height_r < HEIGHT_W'(MIN_EDGE)) begin
      last_row = ROW_W'(MIN_EDGE - 1);
    end else if (height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(height_r - 1'b1);
    end
  end

  bf3s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel_in),
    .last_col (last_col),
    .last_row (last_row),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  bf3s_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  bf3s_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .filter_mode (mode_r),
    .q_empty     (q_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel   (out_pixel_out),
    .out_last    (out_frame_last)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import bf3s_pkg::*;

  localparam int MEAN_DIV     = 9;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    pix_t pixel;
    logic last;
  } out_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_pixel_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_pixel_out;
  logic                  out_frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Idling odds in percent per cycle, and a long receiver hold-off request
  int unsigned snd_idle_pct = 10;
  int unsigned rcv_idle_pct = 79;
  int unsigned hold_req     = 0;

  int unsigned pixels_sent = 0;
  int unsigned fail_count  = 0;

  // Filter state as the block should hold it
  pix_t                line_older [MAX_WIDTH];
  pix_t                line_newer [MAX_WIDTH];
  pix_t                nbhd [9];
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic                mode_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  out_beat_t pending_out [$];

  box_filter_3x3_sharpen u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #4_000_000;
    $display("box_filter_3x3_sharpen regression: fail");
    $finish;
  end

  // Advance the raster by one pixel and queue the filtered beat it produces, if any
  task automatic filter_step(input pix_t px);
    int unsigned w, h, sum, mean, ctr, res;
    logic        row_end, frame_end;
    pix_t        top, mid;
    int          k;
    w = (width_r < MIN_EDGE) ? MIN_EDGE : (width_r > MAX_WIDTH) ? MAX_WIDTH : width_r;
    h = (height_r < MIN_EDGE) ? MIN_EDGE : (height_r > MAX_HEIGHT) ? MAX_HEIGHT : height_r;
    row_end   = (col_pos >= w - 1);
    frame_end = (row_pos >= h - 1);

    // Rotate the line stores at this column
    top = line_older[col_pos];
    mid = line_newer[col_pos];
    line_older[col_pos] = mid;
    line_newer[col_pos] = px;

    // Shift the window left, newest column enters on the right
    for (k = 0; k < 3; k++) begin
      nbhd[k*3]   = nbhd[k*3+1];
      nbhd[k*3+1] = nbhd[k*3+2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = px;

    if (row_pos >= 2 && col_pos >= 2) begin
      sum = 0;
      for (k = 0; k < 9; k++) sum += nbhd[k];
      mean = sum / MEAN_DIV;
      ctr  = nbhd[4];
      if (mode_r == MODE_SHARPEN) begin
        res = ctr + ((mean > ctr) ? mean - ctr : ctr - mean);
        if (res > 255) res = 255;
      end else begin
        res = mean;
      end
      pending_out.push_back('{pixel: pix_t'(res), last: row_end && frame_end});
    end

    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  function automatic pix_t rand_pixel();
    if ($urandom_range(99) < 20) return $urandom_range(1) ? 8'hFF : 8'h00;
    return pix_t'($urandom_range(255));
  endfunction

  // Offer one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input pix_t px);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (in_ready !== 1'b1);
    filter_step(px);
    pixels_sent++;
  endtask

  // Hold the input, let every expected beat arrive, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:   mode_r   = data[0];
      CFG_WIDTH:  width_r  = data[WIDTH_W-1:0];
      CFG_HEIGHT: height_r = data[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Send random pixels until the raster wraps back to the frame start;
  // optionally rewrite a register in the middle of the frame
  task automatic send_frame(input int unsigned midwrite_permille);
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] d;
    do begin
      if ($urandom_range(999) < midwrite_permille) begin
        idx = cfg_idx_t'($urandom_range(0, 3));
        case (idx)
          CFG_WIDTH:  d = CFG_DATA_W'($urandom_range(3, 16));
          CFG_HEIGHT: d = CFG_DATA_W'($urandom_range(3, 10));
          default:    d = CFG_DATA_W'($urandom);
        endcase
        write_reg(idx, d);
      end
      send_pixel(rand_pixel());
    end while (col_pos != 0 || row_pos != 0);
  endtask

  // Reset geometry: check that results line up with a 512-pixel row, then
  // shrink both edges mid-frame so the current pixel closes the frame.
  // The two full rows also fill the low line store entries that later
  // mid-frame widening reads.
  task automatic test_reset_defaults();
    repeat (2 * WIDTH_RST + 4) send_pixel(rand_pixel());
    write_reg(CFG_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(3));
    send_pixel(rand_pixel());
  endtask

  // Smallest frames: full-scale average, sharpen saturation, sharpen of a dark center
  task automatic test_corner_frames();
    int k;
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_AVERAGE));
    repeat (9) send_pixel(8'hFF);
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_SHARPEN));
    for (k = 0; k < 9; k++) send_pixel((k == 4) ? 8'hFF : 8'h00);
    for (k = 0; k < 9; k++) send_pixel((k == 4) ? 8'h00 : 8'hFF);
  endtask

  // Edges below three act as three, bits above a field are dropped, and a
  // write to the spare index changes nothing
  task automatic test_geometry_limits();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_AVERAGE));
    write_reg(CFG_WIDTH, 13'h0800);
    write_reg(CFG_HEIGHT, 13'h0000);
    send_frame(0);
    write_reg(CFG_NONE, 13'h1FFF);
    send_frame(0);
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_SHARPEN));
    write_reg(CFG_WIDTH, CFG_DATA_W'(1));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
    send_frame(0);
  endtask

  // Small random frames with random mode and geometry, some rewritten mid-frame
  task automatic test_random_frames(input int unsigned n_pixels);
    int unsigned           stop_at;
    logic [CFG_DATA_W-1:0] d;
    stop_at = pixels_sent + n_pixels;
    while (pixels_sent < stop_at) begin
      write_reg(CFG_MODE, CFG_DATA_W'($urandom));
      if ($urandom_range(99) < 70) begin
        d = ($urandom_range(99) < 10) ? CFG_DATA_W'($urandom_range(0, 2))
                                      : CFG_DATA_W'($urandom_range(3, 12));
        d[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W-WIDTH_W)'($urandom_range(0, 3));
        write_reg(CFG_WIDTH, d);
      end
      if ($urandom_range(99) < 70) begin
        d = ($urandom_range(99) < 10) ? CFG_DATA_W'($urandom_range(0, 2))
                                      : CFG_DATA_W'($urandom_range(3, 8));
        write_reg(CFG_HEIGHT, d);
      end
      if ($urandom_range(99) < 5) write_reg(CFG_NONE, CFG_DATA_W'($urandom));
      send_frame(15);
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    write_reg(CFG_WIDTH, CFG_DATA_W'(8));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(6));
    hold_req = 300;
    send_frame(0);
    wait_idle();
    send_frame(0);
  endtask

  // Drive out_ready: random stalls, or a counted hold-off when requested
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest expected one
  always @(posedge clk) begin : check_out
    out_beat_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_out.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected beat: pixel_out %0d frame_last %0b",
                   $time, out_pixel_out, out_frame_last);
      end else begin
        want = pending_out.pop_front();
        if (out_pixel_out !== want.pixel || out_frame_last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] mismatch: pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                     $time, want.pixel, out_pixel_out, want.last, out_frame_last);
        end
      end
    end
  end

  initial begin : main
    int k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_NONE;
    cfg_data    = '0;
    mode_r      = MODE_AVERAGE;
    width_r     = WIDTH_RST;
    height_r    = HEIGHT_RST;
    col_pos     = 0;
    row_pos     = 0;
    for (k = 0; k < 9; k++) nbhd[k] = '0;
    for (k = 0; k < MAX_WIDTH; k++) begin
      line_older[k] = '0;
      line_newer[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_corner_frames();
    test_geometry_limits();
    test_random_frames(50);
    snd_idle_pct = 79;
    rcv_idle_pct = 10;
    test_random_frames(50);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_frames(50);
    test_backpressure();

    wait_idle();
    if (pending_out.size() != 0)
      $display("%0d expected beats never arrived", pending_out.size());
    if (fail_count == 0 && pending_out.size() == 0) begin
      $display("box_filter_3x3_sharpen regression: pass");
    end else begin
      $display("box_filter_3x3_sharpen regression: fail");
    end
    $finish;
  end

endmodule
